>>> hw/rtl/bvcm_pkg.sv
// ----------------------------------------------------------------------------
// bvcm_pkg: shared types and constants
// Result codes, controller states and fixed widths for the byte vector
// cosine match block.
// ----------------------------------------------------------------------------
package bvcm_pkg;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_MATCH  = 1'b1;

  localparam logic STATUS_STORED = 1'b0;
  localparam logic STATUS_FULL   = 1'b1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam int unsigned LIMIT_W = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd4;
  localparam logic [LIMIT_W-1:0] MAX_RESULTS = 5'd16;

  localparam int unsigned SCORE_W = 16;
  localparam logic [SCORE_W-1:0] SCORE_ONE = 16'd32768;

  // Quotient bits kept by the divider; the score scale 2^15 squared.
  localparam int unsigned QUOT_W = 30;
  localparam int unsigned ROOT_W = 15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLOT,
    ST_DOT,
    ST_ROOT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RT_IDLE,
    RT_MUL,
    RT_DIV,
    RT_SQRT
  } root_state_e;

endpackage

>>> hw/rtl/byte_vector_cosine_match.sv
// ----------------------------------------------------------------------------
// byte_vector_cosine_match: byte vector store with cosine scoring
// Loads documents as byte vectors into slots and scores a query vector by
// cosine similarity in unsigned Q1.15 against slots 0 to min(limit, 16)-1.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                       | handshake
//  ----------+-----------------------------------------------+-----------------
//  request   | mode_i, text_byte_i, last_i                   | start_i & !busy_o
//  result    | kind_o, status_o, slot_o, present_o, score_o,  | result_valid_o
//            | final_result_o                                | (one-cycle strobe)
//  config    | cfg_wdata_i (result_limit)                    | cfg_we_i
//
// Every byte that does not close a query is taken while busy_o stays low; a
// closing load byte puts its status result out on the next cycle while the
// next request is already taken. A closing query byte with a nonzero limit
// raises busy_o while the slots are scored in order: an empty or zero-norm
// slot is reported with score 0 from the select state; a scored slot is
// selected, its dot product is summed one element per RAM read, and the
// divider and square root then form its score.
// Reset clears the document count, positions, query norm and the limit
// (back to 4); the vector RAMs are not cleared. The receiver cannot stall.
//
module byte_vector_cosine_match #(
  parameter int unsigned DOC_SLOTS     = 16,
  parameter int unsigned VECTOR_LENGTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         mode_i,
  input  logic [7:0]                   text_byte_i,
  input  logic                         last_i,
  input  logic                         cfg_we_i,
  input  logic [bvcm_pkg::LIMIT_W-1:0] cfg_wdata_i,
  output logic                         result_valid_o,
  output logic                         kind_o,
  output logic                         status_o,
  output logic [3:0]                   slot_o,
  output logic                         present_o,
  output logic [bvcm_pkg::SCORE_W-1:0] score_o,
  output logic                         final_result_o
);
  import bvcm_pkg::*;

  // Norm and dot product width: VECTOR_LENGTH squares of a byte.
  localparam int unsigned NW   = $clog2(VECTOR_LENGTH * 65025 + 1);
  localparam int unsigned PW   = $clog2(VECTOR_LENGTH + 1);
  localparam int unsigned CW   = $clog2(DOC_SLOTS + 1);
  localparam int unsigned SW   = (DOC_SLOTS > 1) ? $clog2(DOC_SLOTS) : 1;
  localparam int unsigned DD   = DOC_SLOTS * VECTOR_LENGTH;
  localparam int unsigned AW   = (DD > 1) ? $clog2(DD) : 1;
  localparam int unsigned QAW  = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;

  ctrl_state_e state_q, state_d;

  // Control registers
  logic [CW-1:0]      count_q, count_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic [PW-1:0]      qlen_q, qlen_d;
  logic [NW-1:0]      qnorm_q, qnorm_d;
  logic [NW-1:0]      cur_norm_q, cur_norm_d;
  logic [LIMIT_W-1:0] limit_q;
  logic [LIMIT_W-1:0] idx_q, idx_d;
  logic [LIMIT_W-1:0] k_q, k_d;
  logic [PW-1:0]      j_q, j_d;
  logic [PW-1:0]      n_q, n_d;
  logic [NW-1:0]      acc_q, acc_d;
  logic               rd_vld_q, rd_vld_d;
  logic [NW-1:0]      dnorm_q, dnorm_d;

  // Per-slot length and norm, written while loading, read at the scored slot
  logic [PW-1:0] doc_len_q  [DOC_SLOTS];
  logic [NW-1:0] doc_norm_q [DOC_SLOTS];

  // Result register
  logic               out_vld_q, out_vld_d;
  logic               kind_q, kind_d;
  logic               status_q, status_d;
  logic [3:0]         slot_q, slot_d;
  logic               present_q, present_d;
  logic [SCORE_W-1:0] score_q, score_d;
  logic               final_q, final_d;

  logic               accept, full, doc_wr, q_wr, has, slot_last, root_start;
  logic [15:0]        sq;
  logic [SW-1:0]      load_slot, score_slot;
  logic [LIMIT_W-1:0] k_next;
  logic [AW-1:0]      doc_waddr, doc_raddr;
  logic [7:0]         doc_rdata, q_rdata;
  logic [NW-1:0]      sel_dnorm;
  logic [PW-1:0]      sel_dlen;
  logic               root_done;
  logic [SCORE_W-1:0] root_score;

  assign busy_o     = (state_q != ST_IDLE);
  assign accept     = start_i && !busy_o;
  assign full       = (32'(count_q) >= 32'(DOC_SLOTS));
  assign doc_wr     = accept && (mode_i == MODE_LOAD) && !full
                      && (32'(pos_q) < 32'(VECTOR_LENGTH));
  assign q_wr       = accept && (mode_i == MODE_QUERY)
                      && (32'(qlen_q) < 32'(VECTOR_LENGTH));
  assign sq         = {8'b0, text_byte_i} * {8'b0, text_byte_i};
  assign load_slot  = SW'(count_q);
  assign score_slot = SW'(idx_q);
  assign k_next     = (limit_q > MAX_RESULTS) ? MAX_RESULTS : limit_q;
  assign has        = (32'(idx_q) < 32'(count_q));
  assign slot_last  = (idx_q + LIMIT_W'(1)) == k_q;
  assign sel_dnorm  = doc_norm_q[score_slot];
  assign sel_dlen   = doc_len_q[score_slot];

  assign doc_waddr  = AW'(load_slot) * AW'(VECTOR_LENGTH) + AW'(pos_q);
  assign doc_raddr  = AW'(score_slot) * AW'(VECTOR_LENGTH) + AW'(j_q);

  bvcm_ram #(
    .WIDTH (8),
    .DEPTH (DD)
  ) u_doc_ram (
    .clk_i   (clk_i),
    .we_i    (doc_wr),
    .waddr_i (doc_waddr),
    .wdata_i (text_byte_i),
    .raddr_i (doc_raddr),
    .rdata_o (doc_rdata)
  );

  bvcm_ram #(
    .WIDTH (8),
    .DEPTH (VECTOR_LENGTH)
  ) u_query_ram (
    .clk_i   (clk_i),
    .we_i    (q_wr),
    .waddr_i (qlen_q[QAW-1:0]),
    .wdata_i (text_byte_i),
    .raddr_i (j_q[QAW-1:0]),
    .rdata_o (q_rdata)
  );

  bvcm_root #(
    .NW (NW)
  ) u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .dot_i   (acc_q),
    .qnorm_i (qnorm_q),
    .dnorm_i (dnorm_q),
    .done_o  (root_done),
    .score_o (root_score)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && mode_i == MODE_QUERY && last_i && k_next != '0) begin
          state_d = ST_SLOT;
        end
      end
      ST_SLOT: begin
        if (has && qnorm_q != '0 && sel_dnorm != '0) begin
          state_d = ST_DOT;
        end else if (slot_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_DOT:  if (j_q == n_q && !rd_vld_q) state_d = ST_ROOT;
      ST_ROOT: begin
        if (root_done) state_d = slot_last ? ST_IDLE : ST_SLOT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    count_d    = count_q;
    pos_d      = pos_q;
    qlen_d     = qlen_q;
    qnorm_d    = qnorm_q;
    cur_norm_d = cur_norm_q;
    idx_d      = idx_q;
    k_d        = k_q;
    j_d        = j_q;
    n_d        = n_q;
    acc_d      = acc_q;
    rd_vld_d   = 1'b0;
    dnorm_d    = dnorm_q;
    root_start = 1'b0;
    out_vld_d  = 1'b0;
    kind_d     = kind_q;
    status_d   = status_q;
    slot_d     = slot_q;
    present_d  = present_q;
    score_d    = score_q;
    final_d    = final_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && mode_i == MODE_LOAD) begin
          if (doc_wr) begin
            cur_norm_d = (pos_q == '0) ? NW'(sq) : cur_norm_q + NW'(sq);
            pos_d      = pos_q + PW'(1);
          end
          if (last_i) begin
            // Report the slot, then advance to the next one
            out_vld_d = 1'b1;
            kind_d    = KIND_STATUS;
            status_d  = full ? STATUS_FULL : STATUS_STORED;
            slot_d    = full ? 4'd0 : 4'(count_q);
            present_d = 1'b0;
            score_d   = '0;
            final_d   = 1'b0;
            if (!full) count_d = count_q + CW'(1);
            pos_d = '0;
          end
        end else if (accept) begin
          if (q_wr) begin
            qnorm_d = qnorm_q + NW'(sq);
            qlen_d  = qlen_q + PW'(1);
          end
          if (last_i) begin
            idx_d = '0;
            k_d   = k_next;
            if (k_next == '0) begin
              qlen_d  = '0;
              qnorm_d = '0;
            end
          end
        end
      end
      ST_SLOT: begin
        j_d     = '0;
        acc_d   = '0;
        dnorm_d = sel_dnorm;
        n_d     = (qlen_q < sel_dlen) ? qlen_q : sel_dlen;
        if (!(has && qnorm_q != '0 && sel_dnorm != '0)) begin
          // Empty slot or zero norm: score 0 without the root unit
          out_vld_d = 1'b1;
          kind_d    = KIND_MATCH;
          status_d  = STATUS_STORED;
          slot_d    = idx_q[3:0];
          present_d = has;
          score_d   = '0;
          final_d   = slot_last;
          idx_d     = idx_q + LIMIT_W'(1);
          if (slot_last) begin
            qlen_d  = '0;
            qnorm_d = '0;
          end
        end
      end
      ST_DOT: begin
        if (j_q != n_q) begin
          rd_vld_d = 1'b1;
          j_d      = j_q + PW'(1);
        end
        if (rd_vld_q) begin
          acc_d = acc_q + NW'({8'b0, doc_rdata} * {8'b0, q_rdata});
        end
        if (j_q == n_q && !rd_vld_q) root_start = 1'b1;
      end
      ST_ROOT: begin
        if (root_done) begin
          out_vld_d = 1'b1;
          kind_d    = KIND_MATCH;
          status_d  = STATUS_STORED;
          slot_d    = idx_q[3:0];
          present_d = 1'b1;
          score_d   = root_score;
          final_d   = slot_last;
          idx_d     = idx_q + LIMIT_W'(1);
          if (slot_last) begin
            qlen_d  = '0;
            qnorm_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      pos_q     <= '0;
      qlen_q    <= '0;
      qnorm_q   <= '0;
      limit_q   <= LIMIT_RESET;
      idx_q     <= '0;
      k_q       <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      qlen_q    <= qlen_d;
      qnorm_q   <= qnorm_d;
      idx_q     <= idx_d;
      k_q       <= k_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  // Payload and per-slot tables: no reset
  always_ff @(posedge clk_i) begin
    cur_norm_q <= cur_norm_d;
    j_q        <= j_d;
    n_q        <= n_d;
    acc_q      <= acc_d;
    dnorm_q    <= dnorm_d;
    kind_q     <= kind_d;
    status_q   <= status_d;
    slot_q     <= slot_d;
    present_q  <= present_d;
    score_q    <= score_d;
    final_q    <= final_d;
    if (doc_wr) begin
      doc_len_q[load_slot]  <= pos_q + PW'(1);
      doc_norm_q[load_slot] <= cur_norm_d;
    end
  end

  assign result_valid_o = out_vld_q;
  assign kind_o         = kind_q;
  assign status_o       = status_q;
  assign slot_o         = slot_q;
  assign present_o      = present_q;
  assign score_o        = score_q;
  assign final_result_o = final_q;

endmodule

>>> hw/rtl/bvcm_ram.sv
// ----------------------------------------------------------------------------
// bvcm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bvcm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/bvcm_root.sv
// ----------------------------------------------------------------------------
// bvcm_root: cosine score unit
// Computes min(32768, floor(32768*dot/sqrt(na*nb))) with a bit-serial
// divider followed by a bit-serial square root.
// ----------------------------------------------------------------------------
module bvcm_root #(
  parameter int unsigned NW = 22
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [NW-1:0]                dot_i,
  input  logic [NW-1:0]                qnorm_i,
  input  logic [NW-1:0]                dnorm_i,
  output logic                         done_o,
  output logic [bvcm_pkg::SCORE_W-1:0] score_o
);
  import bvcm_pkg::*;

  localparam int unsigned PW  = 2 * NW;
  localparam int unsigned XW  = PW + QUOT_W;
  localparam int unsigned CNW = $clog2(XW + 1);

  root_state_e state_q, state_d;

  logic [NW-1:0]     dot_q, qn_q, dn_q;
  logic [PW-1:0]     p_q, p_d;
  logic [XW-1:0]     num_q, num_d;
  logic [PW-1:0]     rem_q, rem_d;
  logic [QUOT_W-1:0] quo_q, quo_d;
  logic              ovf_q, ovf_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNW-1:0]    cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [SCORE_W-1:0] score_q, score_d;

  logic [PW:0]       trial;
  logic              ge;
  logic [ROOT_W-1:0] try_root;
  logic [QUOT_W-1:0] try_sq;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      RT_IDLE: if (start_i) state_d = RT_MUL;
      RT_MUL:  state_d = RT_DIV;
      RT_DIV:  if (cnt_q == CNW'(1)) state_d = RT_SQRT;
      RT_SQRT: if (cnt_q == CNW'(1)) state_d = RT_IDLE;
      default: state_d = RT_IDLE;
    endcase
  end

  assign trial    = {rem_q, num_q[XW-1]};
  assign ge       = trial >= {1'b0, p_q};
  assign try_root = root_q | (ROOT_W'(1) << (cnt_q - CNW'(1)));
  assign try_sq   = QUOT_W'(try_root) * QUOT_W'(try_root);

  // Datapath
  always_comb begin
    p_d     = p_q;
    num_d   = num_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    ovf_d   = ovf_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    score_d = score_q;
    case (state_q)
      RT_MUL: begin
        p_d   = PW'(qn_q) * PW'(dn_q);
        num_d = {PW'(dot_q) * PW'(dot_q), QUOT_W'(0)};
        rem_d = '0;
        quo_d = '0;
        ovf_d = 1'b0;
        cnt_d = CNW'(XW);
      end
      RT_DIV: begin
        rem_d = ge ? PW'(trial - {1'b0, p_q}) : PW'(trial);
        num_d = num_q << 1;
        quo_d = {quo_q[QUOT_W-2:0], ge};
        ovf_d = ovf_q | quo_q[QUOT_W-1];
        cnt_d = cnt_q - CNW'(1);
        if (cnt_q == CNW'(1)) begin
          root_d = '0;
          cnt_d  = CNW'(ROOT_W);
        end
      end
      RT_SQRT: begin
        if (try_sq <= quo_q) root_d = try_root;
        cnt_d = cnt_q - CNW'(1);
        if (cnt_q == CNW'(1)) begin
          done_d  = 1'b1;
          score_d = ovf_q ? SCORE_ONE
                          : {1'b0, ((try_sq <= quo_q) ? try_root : root_q)};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RT_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == RT_IDLE && start_i) begin
      dot_q <= dot_i;
      qn_q  <= qnorm_i;
      dn_q  <= dnorm_i;
    end
    p_q     <= p_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    ovf_q   <= ovf_d;
    root_q  <= root_d;
    cnt_q   <= cnt_d;
    score_q <= score_d;
  end

  assign done_o  = done_q;
  assign score_o = score_q;

endmodule
